>>> design/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;
  localparam int TOTAL_UNITS = 1024;
  localparam int LG         = $clog2(TOTAL_UNITS);
  localparam int NODE_COUNT = 2 * TOTAL_UNITS - 1;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LVL_W      = $clog2(LG + 1);
  localparam int ADDR_W     = 10;
  localparam int SIZE_W     = 11;

  typedef enum logic [1:0] {
    NS_UNUSED = 2'd0,
    NS_FREE   = 2'd1,
    NS_ALLOC  = 2'd2,
    NS_SPLIT  = 2'd3
  } node_state_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BAD_SZ  = 2'd2,
    ST_BAD_ADR = 2'd3
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_addr;
    logic [SIZE_W-1:0] block_size;
  } res_t;
endpackage

>>> design/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/buddy_block_allocator_unit.sv
// Top level of the buddy block allocator: sequencer over the node-state RAM.
// Pulse start with busy low to issue a request; exactly one result follows,
// shown for one cycle with out_valid, and cannot be stalled. After reset a
// clearing pass runs over every node of the node RAM with busy high. An
// allocate examines nodes one by one in the level scan (up to the whole
// tree in the worst case), then splits one level at a time; a free
// descends level by level, then merges with free buddies upward.
// All cost comes from the single node RAM port, one access per cycle.
module buddy_block_allocator_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bba_pkg::req_t in_req,
  output logic          out_valid,
  output bba_pkg::res_t out_res
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ARD, S_ACHK, S_SP0, S_SP1, S_SP2, S_AFIN,
    S_FRD, S_FCHK, S_MRD, S_MCHK, S_MW0, S_MW1, S_MW2
  } state_t;

  state_t            state_r;
  logic [NODE_W-1:0] node_r, clr_r;
  logic [LVL_W-1:0]  lvl_r, want_lvl_r;
  logic [ADDR_W-1:0] k_r, addr_r;
  logic              out_valid_r;
  res_t              out_res_r;

  logic              mem_we;
  logic [NODE_W-1:0] mem_addr;
  logic [1:0]        mem_wdata, mem_rdata;

  logic [NODE_W-1:0] scan_first, scan_node, left_n, right_n, buddy_n, parent_n;
  logic [ADDR_W-1:0] sz_m1;
  logic [LVL_W-1:0]  clog;

  bba_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_addr),
    .wdata(mem_wdata),
    .raddr(mem_addr),
    .rdata(mem_rdata)
  );

  assign scan_first = (NODE_W'(1) << lvl_r) - NODE_W'(1);
  assign scan_node  = scan_first + NODE_W'(k_r);
  assign left_n     = (node_r << 1) + NODE_W'(1);
  assign right_n    = (node_r << 1) + NODE_W'(2);
  assign buddy_n    = node_r[0] ? node_r + NODE_W'(1) : node_r - NODE_W'(1);
  assign parent_n   = (node_r - NODE_W'(1)) >> 1;

  assign sz_m1 = ADDR_W'(in_req.req_size - SIZE_W'(1));
  always_comb begin
    clog = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      if (sz_m1[i]) begin
        clog = LVL_W'(i + 1);
      end
    end
  end

  function automatic res_t free_res(logic [ADDR_W-1:0] a, logic [LVL_W-1:0] l);
    logic [LVL_W-1:0]  sh;
    res_t              r;
    sh = LVL_W'(LG) - l;
    r.status     = ST_OK;
    r.block_addr = a & ~ADDR_W'((SIZE_W'(1) << sh) - SIZE_W'(1));
    r.block_size = SIZE_W'(1) << sh;
    return r;
  endfunction

  function automatic res_t err_res(status_t s);
    res_t r;
    r.status     = s;
    r.block_addr = '0;
    r.block_size = '0;
    return r;
  endfunction

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = NS_UNUSED;
    mem_addr  = node_r;
    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = (clr_r == '0) ? NS_FREE : NS_UNUSED;
      end
      S_ARD:  mem_addr = scan_node;
      S_SP0: begin
        mem_we = 1'b1; mem_wdata = NS_SPLIT;
      end
      S_SP1: begin
        mem_we = 1'b1; mem_wdata = NS_FREE; mem_addr = left_n;
      end
      S_SP2: begin
        mem_we = 1'b1; mem_wdata = NS_FREE; mem_addr = right_n;
      end
      S_AFIN: begin
        mem_we = 1'b1; mem_wdata = NS_ALLOC;
      end
      S_FCHK: begin
        mem_we    = !(mem_rdata == NS_SPLIT && lvl_r < LVL_W'(LG)) &&
                    ((addr_r & ADDR_W'((SIZE_W'(1) << (LVL_W'(LG) - lvl_r)) -
                      SIZE_W'(1))) == '0) &&
                    (mem_rdata == NS_FREE || mem_rdata == NS_ALLOC);
        mem_wdata = NS_FREE;
      end
      S_MRD:  mem_addr = buddy_n;
      S_MW0: begin
        mem_we = 1'b1; mem_wdata = NS_UNUSED;
      end
      S_MW1: begin
        mem_we = 1'b1; mem_wdata = NS_UNUSED; mem_addr = buddy_n;
      end
      S_MW2: begin
        mem_we = 1'b1; mem_wdata = NS_FREE; mem_addr = parent_n;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + NODE_W'(1);
          if (clr_r == NODE_W'(NODE_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            addr_r <= in_req.req_addr;
            node_r <= '0;
            k_r    <= '0;
            if (in_req.req_type == REQ_ALLOC) begin
              if (in_req.req_size == '0 || in_req.req_size > SIZE_W'(TOTAL_UNITS)) begin
                out_res_r   <= err_res(ST_BAD_SZ);
                out_valid_r <= 1'b1;
              end else begin
                lvl_r      <= LVL_W'(LG) - clog;
                want_lvl_r <= LVL_W'(LG) - clog;
                state_r    <= S_ARD;
              end
            end else begin
              lvl_r   <= '0;
              state_r <= S_FRD;
            end
          end
        end
        S_ARD: state_r <= S_ACHK;
        S_ACHK: begin
          if (mem_rdata == NS_FREE) begin
            node_r  <= scan_node;
            addr_r  <= ADDR_W'(k_r << (LVL_W'(LG) - lvl_r));
            state_r <= (lvl_r == want_lvl_r) ? S_AFIN : S_SP0;
          end else if (NODE_W'(k_r) == scan_first) begin
            if (lvl_r == '0) begin
              out_res_r   <= err_res(ST_NO_FREE);
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              lvl_r   <= lvl_r - LVL_W'(1);
              k_r     <= '0;
              state_r <= S_ARD;
            end
          end else begin
            k_r     <= k_r + ADDR_W'(1);
            state_r <= S_ARD;
          end
        end
        S_SP0: state_r <= S_SP1;
        S_SP1: state_r <= S_SP2;
        S_SP2: begin
          node_r  <= left_n;
          lvl_r   <= lvl_r + LVL_W'(1);
          state_r <= (lvl_r + LVL_W'(1) == want_lvl_r) ? S_AFIN : S_SP0;
        end
        S_AFIN: begin
          out_res_r.status     <= ST_OK;
          out_res_r.block_addr <= addr_r;
          out_res_r.block_size <= SIZE_W'(1) << (LVL_W'(LG) - lvl_r);
          out_valid_r          <= 1'b1;
          state_r              <= S_IDLE;
        end
        S_FRD: state_r <= S_FCHK;
        S_FCHK: begin
          if (mem_rdata == NS_SPLIT && lvl_r < LVL_W'(LG)) begin
            node_r  <= ((addr_r >> (LVL_W'(LG - 1) - lvl_r)) & ADDR_W'(1)) != '0 ?
                       right_n : left_n;
            lvl_r   <= lvl_r + LVL_W'(1);
            state_r <= S_FRD;
          end else if (mem_we) begin
            if (node_r == '0) begin
              out_res_r   <= free_res(addr_r, lvl_r);
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_MRD;
            end
          end else begin
            out_res_r   <= err_res(ST_BAD_ADR);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_MRD: state_r <= S_MCHK;
        S_MCHK: begin
          if (mem_rdata == NS_FREE) begin
            state_r <= S_MW0;
          end else begin
            out_res_r   <= free_res(addr_r, lvl_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_MW0: state_r <= S_MW1;
        S_MW1: state_r <= S_MW2;
        S_MW2: begin
          node_r <= parent_n;
          lvl_r  <= lvl_r - LVL_W'(1);
          if (parent_n == '0) begin
            out_res_r   <= free_res(addr_r, lvl_r - LVL_W'(1));
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_MRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
endmodule
